FILE: rtl/core/bmorph_pkg.sv
`default_nettype none

package bmorph_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int HEIGHT_LIMIT = 1024;
	localparam int DIM_W        = 11;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = $clog2(HEIGHT_LIMIT + 2);
	localparam int WID_W        = (DIM_W > $clog2(MAX_WIDTH + 1)) ? DIM_W : $clog2(MAX_WIDTH + 1);
	localparam int WIN          = 3;
	localparam int LINE_W       = 2;

	localparam logic MODE_ERODE = 1'b1;
	localparam logic REQ_FLUSH  = 1'b1;

	typedef enum logic [1:0] {
		REG_OP_MODE      = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2,
		REG_BORDER_VALUE = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic top;
		logic bottom;
		logic side;
	} cell_mask_t;

	typedef struct packed {
		logic any_set;
		logic all_set;
	} cell_red_t;

	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
	} bound_t;

endpackage

`default_nettype wire

FILE: rtl/core/bmorph_in_if.sv
`default_nettype none

interface bmorph_in_if;
	logic valid;
	logic ready;
	logic req_type;
	logic pixel_in;

	modport source (output valid, output req_type, output pixel_in, input ready);
	modport sink (input valid, input req_type, input pixel_in, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bmorph_out_if.sv
`default_nettype none

interface bmorph_out_if;
	logic valid;
	logic ready;
	logic result_pixel;
	logic frame_end;

	modport source (output valid, output result_pixel, output frame_end, input ready);
	modport sink (input valid, input result_pixel, input frame_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bmorph_ram.sv
`default_nettype none

module bmorph_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/bmorph_cell.sv
`default_nettype none

module bmorph_cell
	import bmorph_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic             clear,
	input  wire logic [WIN-1:0]   col_in,
	input  wire cell_mask_t       mask,
	input  wire logic             border,
	output logic      [WIN-1:0]   col_q,
	output cell_red_t             red
);

	logic [WIN-1:0] masked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (clear) begin
			col_q <= '0;
		end else if (advance) begin
			col_q <= col_in;
		end
	end

	always_comb begin
		for (int k = 0; k < WIN; k++) begin
			if (mask.side || (k == 0 && mask.top) || (k == WIN - 1 && mask.bottom)) begin
				masked[k] = border;
			end else begin
				masked[k] = col_in[k];
			end
		end
	end

	assign red.any_set = |masked;
	assign red.all_set = &masked;

endmodule

`default_nettype wire

FILE: rtl/core/binary_morphology_3x3.sv
// Streaming 3x3 binary dilation / erosion with an all-ones element.
// pixels: one item per transfer; req_type selects a pixel or a flush tick.
// Pixels arrive in raster order; after the last pixel of a frame,
// image_width + 1 flush ticks (or pixels, which are then discarded) drain it.
// A flush tick before the frame is complete is taken and dropped.
// results: one pixel per transfer in raster order, frame_end on the last one.
// The result for pixel (r, c) is produced by the item taken image_width + 1
// items later; it is computed in the window stage and held in the output register.
// Throughput is one item per cycle unless results stalls: the line store takes
// a registered read on transfer and writes back from the window stage on its
// own write port. While results is stalled with a result held, pixels waits
// unless the window stage is empty or its item causes no result.
// Config writes (wr_en, wr_index, wr_data) must come while idle (unenforced); a
// width or height write restarts the frame and clears the window. Reset clears
// the pipeline, positions and window, and loads mode 0, 10x10, border 0; the
// line store needs no clearing since stale entries only feed masked positions.
`default_nettype none

module binary_morphology_3x3
	import bmorph_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	bmorph_in_if.sink              pixels,
	bmorph_out_if.source           results,
	input  wire logic              wr_en,
	input  wire reg_index_t        wr_index,
	input  wire logic [DIM_W-1:0]  wr_data
);

	logic             mode_q;
	logic             border_q;
	logic [WID_W-1:0] width_q;
	logic [ROW_W-1:0] height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             restart;

	logic              valid_s1;
	logic              x_s1;
	logic [COL_W-1:0]  idx_s1;
	logic              emit_s1;
	logic              end_s1;
	bound_t            bnd_s1;
	logic              fwd_s1;
	logic [LINE_W-1:0] fwd_data_s1;

	logic out_valid_q;
	logic res_pixel_q;
	logic res_end_q;

	logic   flush;
	logic   draining;
	logic   drop;
	logic   take;
	logic   x_in;
	logic   c_nz;
	logic   emit;
	logic   fe;
	logic   last_col;
	bound_t bnd;
	logic   s1_fire;

	logic [LINE_W-1:0] ram_rdata;
	logic [LINE_W-1:0] line_rd;
	logic [LINE_W-1:0] line_wr;
	logic [WIN-1:0]    new_col;
	logic [WIN-1:0]    win_col [WIN];
	cell_red_t         red [WIN];
	logic [WIN-1:0]    any_v;
	logic [WIN-1:0]    all_v;
	logic              result;

	assign restart = wr_en && (wr_index == REG_IMAGE_WIDTH || wr_index == REG_IMAGE_HEIGHT);

	// front end: position bookkeeping
	assign flush    = (pixels.req_type == REQ_FLUSH);
	assign draining = (row_q >= height_q);
	assign drop     = flush && !draining;
	assign s1_fire  = valid_s1 && (!emit_s1 || !out_valid_q || results.ready);
	assign pixels.ready = !valid_s1 || s1_fire;
	assign take     = pixels.valid && pixels.ready && !drop;
	assign x_in     = draining ? 1'b0 : pixels.pixel_in;
	assign c_nz     = (col_q != '0);
	assign last_col = (WID_W'(col_q) + WID_W'(1) == width_q);
	assign fe       = !c_nz && (row_q == height_q + ROW_W'(1));

	always_comb begin
		if (c_nz) begin
			emit       = (row_q >= ROW_W'(1));
			bnd.top    = (row_q == ROW_W'(1));
			bnd.bottom = (row_q == height_q);
			bnd.left   = (col_q == COL_W'(1));
			bnd.right  = 1'b0;
		end else begin
			emit       = (row_q >= ROW_W'(2));
			bnd.top    = (row_q == ROW_W'(2));
			bnd.bottom = (row_q == height_q + ROW_W'(1));
			bnd.left   = (width_q == WID_W'(1));
			bnd.right  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			border_q <= 1'b0;
			width_q  <= WID_W'(10);
			height_q <= ROW_W'(10);
			col_q    <= '0;
			row_q    <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_OP_MODE: begin
					mode_q <= wr_data[0];
				end
				REG_IMAGE_WIDTH: begin
					if (wr_data == '0) begin
						width_q <= WID_W'(1);
					end else if (WID_W'(wr_data) > WID_W'(MAX_WIDTH)) begin
						width_q <= WID_W'(MAX_WIDTH);
					end else begin
						width_q <= WID_W'(wr_data);
					end
				end
				REG_IMAGE_HEIGHT: begin
					if (wr_data == '0) begin
						height_q <= ROW_W'(1);
					end else if (wr_data > DIM_W'(HEIGHT_LIMIT)) begin
						height_q <= ROW_W'(HEIGHT_LIMIT);
					end else begin
						height_q <= ROW_W'(wr_data);
					end
				end
				REG_BORDER_VALUE: begin
					border_q <= wr_data[0];
				end
				default: begin
				end
			endcase
			if (restart) begin
				col_q <= '0;
				row_q <= '0;
			end
		end else if (take) begin
			if (fe) begin
				col_q <= '0;
				row_q <= '0;
			end else if (last_col) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// window stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_s1        <= x_in;
			idx_s1      <= col_q;
			emit_s1     <= emit;
			end_s1      <= fe;
			bnd_s1      <= bnd;
			fwd_s1      <= s1_fire && (idx_s1 == col_q);
			fwd_data_s1 <= line_wr;
		end
	end

	bmorph_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (s1_fire),
		.waddr (idx_s1),
		.wdata (line_wr),
		.re    (take),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	// bit 1: upper row, bit 0: lower row
	assign line_rd = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign line_wr = {line_rd[0], x_s1};
	assign new_col = {x_s1, line_rd[0], line_rd[1]};

	for (genvar g = 0; g < WIN; g++) begin : g_cell
		logic [WIN-1:0] cin;
		cell_mask_t     cmask;

		if (g == WIN - 1) begin : g_head
			assign cin        = new_col;
			assign cmask.side = bnd_s1.right;
		end else if (g == 0) begin : g_tail
			assign cin        = win_col[g + 1];
			assign cmask.side = bnd_s1.left;
		end else begin : g_mid
			assign cin        = win_col[g + 1];
			assign cmask.side = 1'b0;
		end
		assign cmask.top    = bnd_s1.top;
		assign cmask.bottom = bnd_s1.bottom;

		bmorph_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (s1_fire),
			.clear   (restart),
			.col_in  (cin),
			.mask    (cmask),
			.border  (border_q),
			.col_q   (win_col[g]),
			.red     (red[g])
		);

		assign any_v[g] = red[g].any_set;
		assign all_v[g] = red[g].all_set;
	end

	assign result = (mode_q == MODE_ERODE) ? &all_v : |any_v;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit_s1) begin
			res_pixel_q <= result;
			res_end_q   <= end_s1;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.result_pixel = res_pixel_q;
	assign results.frame_end    = res_end_q;

endmodule

`default_nettype wire

FILE: verif/morphology_checker.sv
`timescale 1ns / 1ps

module morphology_checker
	import bmorph_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	bmorph_in_if             pix_mon,
	bmorph_out_if            res_mon,
	input  logic             wr_en,
	input  reg_index_t       wr_index,
	input  logic [DIM_W-1:0] wr_data,
	output int               errors,
	output int               pending
);

	typedef struct packed {
		logic pixel;
		logic last;
	} morph_pixel_t;

	morph_pixel_t expected_pixels[$];

	logic             upper_row [MAX_WIDTH];
	logic             lower_row [MAX_WIDTH];
	logic [8:0]       window;
	int               col_pos;
	int               row_pos;
	int               out_pos;
	logic             erode;
	logic             border;
	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;

	function automatic int clamp_dim(input int v, input int top_v);
		if (v < 1)
			return 1;
		if (v > top_v)
			return top_v;
		return v;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("[%0t] morphology mismatch: %s", $time, what);
		errors++;
	endtask

	task automatic restart_frame();
		window = '0;
		col_pos = 0;
		row_pos = 0;
		out_pos = 0;
	endtask

	task automatic apply_write(input reg_index_t idx, input logic [DIM_W-1:0] data);
		case (idx)
			REG_OP_MODE: erode = (data[0] == MODE_ERODE);
			REG_IMAGE_WIDTH: begin
				width_reg = data;
				restart_frame();
			end
			REG_IMAGE_HEIGHT: begin
				height_reg = data;
				restart_frame();
			end
			REG_BORDER_VALUE: border = data[0];
			default: ;
		endcase
	endtask

	task automatic predict_item(input logic flush, input logic pix);
		int w, h, c, r, idx, orow, ocol;
		logic up, lo, tap, any_set, all_set;
		logic [2:0] column;
		morph_pixel_t res;
		w = clamp_dim(int'(width_reg), MAX_WIDTH);
		h = clamp_dim(int'(height_reg), HEIGHT_LIMIT);
		if (flush && row_pos < h)
			return;
		if (row_pos >= h)
			pix = 1'b0;
		c = col_pos;
		r = row_pos;
		idx = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
		up = upper_row[idx];
		lo = lower_row[idx];
		upper_row[idx] = lo;
		lower_row[idx] = pix;
		column = {pix, lo, up};
		for (int i = 0; i < 3; i++)
			window[3*i +: 3] = {column[i], window[3*i+1 +: 2]};
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = r + 1;
		end else begin
			col_pos = c + 1;
		end
		if (c >= 1) begin
			orow = r - 1;
			ocol = c - 1;
		end else begin
			orow = r - 2;
			ocol = w - 1;
		end
		if (orow < 0)
			return;
		any_set = 1'b0;
		all_set = 1'b1;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				tap = window[3*i + j];
				if ((i == 0 && orow == 0) || (i == 2 && orow == h - 1) ||
				    (j == 0 && ocol == 0) || (j == 2 && ocol == w - 1))
					tap = border;
				any_set |= tap;
				all_set &= tap;
			end
		res.pixel = erode ? all_set : any_set;
		res.last = (out_pos == w * h - 1);
		expected_pixels.push_back(res);
		if (res.last) begin
			col_pos = 0;
			row_pos = 0;
			out_pos = 0;
		end else begin
			out_pos++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		morph_pixel_t want;
		if (!arst_n) begin
			expected_pixels.delete();
			for (int k = 0; k < MAX_WIDTH; k++) begin
				upper_row[k] = 1'b0;
				lower_row[k] = 1'b0;
			end
			restart_frame();
			erode = 1'b0;
			border = 1'b0;
			width_reg = DIM_W'(10);
			height_reg = DIM_W'(10);
			errors = 0;
			pending = 0;
		end else begin
			if (res_mon.valid && res_mon.ready) begin
				if (expected_pixels.size() == 0) begin
					flag_mismatch("result transfer with nothing expected");
				end else begin
					want = expected_pixels.pop_front();
					if (res_mon.result_pixel !== want.pixel)
						flag_mismatch($sformatf("result_pixel %b, want %b",
							res_mon.result_pixel, want.pixel));
					if (res_mon.frame_end !== want.last)
						flag_mismatch($sformatf("frame_end %b, want %b",
							res_mon.frame_end, want.last));
				end
			end
			if (wr_en)
				apply_write(wr_index, wr_data);
			if (pix_mon.valid && pix_mon.ready)
				predict_item(pix_mon.req_type == REQ_FLUSH, pix_mon.pixel_in);
			pending = expected_pixels.size();
		end
	end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import bmorph_pkg::*;

	localparam logic REQ_PIXEL   = ~REQ_FLUSH;
	localparam logic MODE_DILATE = ~MODE_ERODE;
	localparam int   ITEM_TARGET = 1750;
	localparam int   HOLD_CYCLES = 300;
	localparam int   SETTLE      = 8;
	localparam int   TAIL        = 20;
	localparam int   IDLE_LIMIT  = 3000;
	localparam int   HOLD_PHASE  = 2;
	localparam int   WIDE_PHASE  = 8;
	localparam int   WIDE_EXTRA  = 8;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             wr_en;
	reg_index_t       wr_index;
	logic [DIM_W-1:0] wr_data;
	int               errors;
	int               pending;

	bit quiet_in;
	bit quiet_out;
	bit hold_results;
	bit geometry_dirty;
	int items_sent;
	int frame_w;
	int frame_h;
	int idle_cycles;

	bmorph_in_if  pixels();
	bmorph_out_if results();

	binary_morphology_3x3 uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixels   (pixels),
		.results  (results),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	morphology_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_mon  (pixels),
		.res_mon  (results),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.errors   (errors),
		.pending  (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((pixels.valid && pixels.ready) || (results.valid && results.ready) || wr_en)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	function automatic int clamp_dim(input int v, input int top_v);
		if (v < 1)
			return 1;
		if (v > top_v)
			return top_v;
		return v;
	endfunction

	function automatic int pick_dim(input int top_v);
		if ($urandom_range(0, 9) == 0)
			return 0;
		return $urandom_range(1, top_v);
	endfunction

	task automatic write_reg(input reg_index_t idx, input logic [DIM_W-1:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic write_style();
		write_reg(REG_OP_MODE, DIM_W'($urandom));
		write_reg(REG_BORDER_VALUE, DIM_W'($urandom));
	endtask

	task automatic set_geometry(input int wv, input int hv);
		write_reg(REG_IMAGE_WIDTH, DIM_W'(wv));
		write_reg(REG_IMAGE_HEIGHT, DIM_W'(hv));
		frame_w = clamp_dim(wv, MAX_WIDTH);
		frame_h = clamp_dim(hv, HEIGHT_LIMIT);
	endtask

	task automatic offer_item(input logic req, input logic pix);
		int gap;
		gap = quiet_in ? 0 : $urandom_range(0, 6);
		repeat (gap) begin
			@(negedge clk);
			pixels.valid <= 1'b0;
		end
		@(negedge clk);
		pixels.valid <= 1'b1;
		pixels.req_type <= req;
		pixels.pixel_in <= pix;
		do @(posedge clk); while (!(pixels.valid && pixels.ready));
	endtask

	// hold off until every pending result has been taken and the pipe is empty
	task automatic settle();
		@(negedge clk);
		pixels.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic feed_pixels(input int count, input int density, input bit noisy);
		for (int k = 0; k < count; k++) begin
			if (noisy && $urandom_range(0, 9) == 0)
				offer_item(REQ_FLUSH, 1'($urandom_range(0, 1)));
			offer_item(REQ_PIXEL, 1'($urandom_range(0, 99) < density));
			items_sent++;
		end
	endtask

	task automatic drain_frame();
		for (int k = 0; k <= frame_w; k++) begin
			offer_item($urandom_range(0, 1) ? REQ_FLUSH : REQ_PIXEL, 1'($urandom_range(0, 1)));
			items_sent++;
		end
	endtask

	task automatic random_phase(input int n);
		int total, density, split, frames;
		bit big;
		big = (n == WIDE_PHASE);
		quiet_in = big || ($urandom_range(0, 3) == 0);
		quiet_out = big || ($urandom_range(0, 3) == 0);
		settle();
		write_style();
		if (n == HOLD_PHASE)
			set_geometry(12, 8);
		else if (big)
			set_geometry(2047, 1);
		else if (geometry_dirty || $urandom_range(0, 2) == 0)
			set_geometry(pick_dim(12), pick_dim(8));
		geometry_dirty = 1'b0;
		if (n == HOLD_PHASE)
			hold_results = 1'b1;
		frames = big ? 1 : $urandom_range(1, 3);
		repeat (frames) begin
			total = frame_w * frame_h;
			case ($urandom_range(0, 2))
				0: density = 5;
				1: density = 50;
				default: density = 95;
			endcase
			if (big) begin
				// one full row at the width limit, a few drain results, then restart
				feed_pixels(frame_w + WIDE_EXTRA, density, 1'b0);
				geometry_dirty = 1'b1;
				return;
			end
			case ($urandom_range(0, 7))
				0: begin
					// abandon the frame; the next phase restarts it
					feed_pixels($urandom_range(0, total - 1), density, 1'b1);
					geometry_dirty = 1'b1;
					return;
				end
				1: begin
					split = $urandom_range(0, total);
					feed_pixels(split, density, 1'b1);
					settle();
					if ($urandom_range(0, 1))
						write_style();
					feed_pixels(total - split, density, 1'b1);
				end
				default: feed_pixels(total, density, 1'b1);
			endcase
			drain_frame();
		end
	endtask

	initial begin
		int gap;
		results.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_results) begin
				@(negedge clk);
				results.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_results = 1'b0;
			end
			gap = quiet_out ? 0 : $urandom_range(0, 6);
			repeat (gap) begin
				@(negedge clk);
				results.ready <= 1'b0;
			end
			@(negedge clk);
			results.ready <= 1'b1;
			do @(posedge clk); while (!(results.valid && results.ready) && !hold_results);
		end
	end

	initial begin
		int phase;
		pixels.valid = 1'b0;
		pixels.req_type = REQ_PIXEL;
		pixels.pixel_in = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_OP_MODE;
		wr_data = '0;
		hold_results = 1'b0;
		geometry_dirty = 1'b0;
		items_sent = 0;
		idle_cycles = 0;
		quiet_in = 1'b0;
		quiet_out = 1'b0;
		frame_w = 10;
		frame_h = 10;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// 1x1 frame from zero geometry, border one
		write_reg(REG_BORDER_VALUE, DIM_W'(1'b1));
		set_geometry(0, 0);
		offer_item(REQ_FLUSH, 1'b1);
		offer_item(REQ_PIXEL, 1'b0);
		offer_item(REQ_FLUSH, 1'b0);
		offer_item(REQ_PIXEL, 1'b1);
		settle();

		// 3x2 erosion, switched to dilation mid-frame
		write_reg(REG_OP_MODE, DIM_W'(MODE_ERODE));
		set_geometry(3, 2);
		offer_item(REQ_PIXEL, 1'b1);
		offer_item(REQ_PIXEL, 1'b1);
		offer_item(REQ_PIXEL, 1'b1);
		offer_item(REQ_PIXEL, 1'b0);
		settle();
		write_reg(REG_OP_MODE, DIM_W'(MODE_DILATE));
		write_reg(REG_BORDER_VALUE, '0);
		offer_item(REQ_PIXEL, 1'b1);
		offer_item(REQ_PIXEL, 1'b0);
		offer_item(REQ_FLUSH, 1'b1);
		offer_item(REQ_PIXEL, 1'b1);
		offer_item(REQ_FLUSH, 1'b0);
		offer_item(REQ_FLUSH, 1'b1);

		// restart a frame in progress
		offer_item(REQ_PIXEL, 1'b1);
		offer_item(REQ_PIXEL, 1'b1);
		settle();
		set_geometry(2, 3);

		phase = 0;
		while (phase <= WIDE_PHASE || items_sent < ITEM_TARGET) begin
			random_phase(phase);
			phase++;
		end

		settle();
		repeat (TAIL) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/bmorph_pkg.sv
rtl/core/bmorph_in_if.sv
rtl/core/bmorph_out_if.sv
rtl/core/bmorph_ram.sv
rtl/core/bmorph_cell.sv
rtl/core/binary_morphology_3x3.sv
verif/morphology_checker.sv
verif/testbench.sv
